>>> sv/dwpd_pkg.sv
// shared types, widths and a helper function for the dual-wheel pd speed control block
`timescale 1ns / 1ps

package dwpd_pkg;

  // field and register widths fixed by the interface
  localparam int FIELD_W      = 32;
  localparam int SENSOR_W     = 16;
  localparam int GAIN_W       = 8;
  localparam int DIST_W       = 24;
  localparam int DRIVE_W      = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  // encoder count width default
  localparam int COUNT_WIDTH_DEF = 32;

  // internal arithmetic widths
  localparam int ERR_EXT_W = 34;   // target - delta + feedback before saturation
  localparam int DIFF_W    = 33;   // error minus previous error
  localparam int PROD_W    = 42;   // 9 bit signed gain times 33 bit operand
  localparam int STEP_W    = 42;   // kp*e + kd*de
  localparam int ACC_W     = 43;   // accumulator plus step
  localparam int CMP_W     = 34;   // metric versus distance compare
  localparam int QUO_W     = 16;   // sensor magnitude quotient
  localparam int FB_W      = 17;   // signed sensor feedback

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP           = 3'd0,
    REG_KD           = 3'd1,
    REG_SENSOR_DIV   = 3'd2,
    REG_LEFT_TARGET  = 3'd3,
    REG_RIGHT_TARGET = 3'd4,
    REG_USE_SENSORS  = 3'd5,
    REG_MOVE_KIND    = 3'd6,
    REG_DIST_TARGET  = 3'd7
  } cfg_reg_t;

  // input request codes
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // move kinds
  localparam logic MOVE_TRANSLATE = 1'b0;
  localparam logic MOVE_ROTATE    = 1'b1;

  // multiply sequence steps
  localparam int MUL_IDX_W = 3;
  localparam logic [MUL_IDX_W-1:0] MUL_KP_LEFT  = 3'd0;
  localparam logic [MUL_IDX_W-1:0] MUL_KD_LEFT  = 3'd1;
  localparam logic [MUL_IDX_W-1:0] MUL_KP_RIGHT = 3'd2;
  localparam logic [MUL_IDX_W-1:0] MUL_KD_RIGHT = 3'd3;
  localparam logic [MUL_IDX_W-1:0] MUL_DRAIN    = 3'd4;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_ERR,
    OP_MUL,
    OP_ACC,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                 op;
    logic [MUL_IDX_W-1:0]   mul_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // clamp a wide signed value to 32 bit signed
  function automatic logic signed [DRIVE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] max_v;
    logic signed [ACC_W-1:0] min_v;
    max_v = 43'sd2147483647;
    min_v = -43'sd2147483648;
    if (v > max_v) begin
      sat32 = max_v[DRIVE_W-1:0];
    end else if (v < min_v) begin
      sat32 = min_v[DRIVE_W-1:0];
    end else begin
      sat32 = v[DRIVE_W-1:0];
    end
  endfunction

endpackage

>>> sv/dwpd_ifs.sv
// valid/ready channel interfaces for the input and result words
`timescale 1ns / 1ps

interface dwpd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic signed [dwpd_pkg::FIELD_W-1:0]   left_count;
  logic signed [dwpd_pkg::FIELD_W-1:0]   right_count;
  logic signed [dwpd_pkg::SENSOR_W-1:0]  sensor_error;

  modport source (output valid, req_type, left_count, right_count, sensor_error,
                  input ready);
  modport sink   (input valid, req_type, left_count, right_count, sensor_error,
                  output ready);
endinterface

interface dwpd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dwpd_pkg::DRIVE_W-1:0]   left_drive;
  logic signed [dwpd_pkg::DRIVE_W-1:0]   right_drive;
  logic                                  move_done;

  modport source (output valid, left_drive, right_drive, move_done, input ready);
  modport sink   (input valid, left_drive, right_drive, move_done, output ready);
endinterface

>>> sv/dwpd_divider.sv
// iterative unsigned divider for the sensor error, four quotient bits per cycle
`timescale 1ns / 1ps

module dwpd_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [dwpd_pkg::QUO_W-1:0]        dividend,
  input  logic [dwpd_pkg::GAIN_W-1:0]       divisor,
  output logic [dwpd_pkg::QUO_W-1:0]        quotient,
  output logic                              done
);

  localparam int QW         = dwpd_pkg::QUO_W;
  localparam int DW         = dwpd_pkg::GAIN_W;
  localparam int BITS_PER   = 4;
  localparam int N_CYC      = QW / BITS_PER;
  localparam int CNT_W      = $clog2(N_CYC);

  logic [QW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // four restoring steps per cycle
  always_comb begin
    logic [DW:0]   trial;
    logic [QW-1:0] q;
    logic [DW-1:0] r;
    q = quo_r;
    r = rem_r;
    for (int i = 0; i < BITS_PER; i++) begin
      trial = {r, q[QW-1]};
      q     = {q[QW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
        q[0]  = 1'b1;
      end
      r = trial[DW-1:0];
    end
    quo_nxt = q;
    rem_nxt = r;
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(N_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> sv/dwpd_datapath.sv
// datapath: config registers, error forming, shared multiplier, accumulators, output word
`timescale 1ns / 1ps

module dwpd_datapath #(
  parameter int COUNT_WIDTH = dwpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [dwpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dwpd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic signed [dwpd_pkg::FIELD_W-1:0]   in_left_count,
  input  logic signed [dwpd_pkg::FIELD_W-1:0]   in_right_count,
  input  logic signed [dwpd_pkg::SENSOR_W-1:0]  in_sensor_error,
  input  dwpd_pkg::dp_cmd_t                     cmd,
  output dwpd_pkg::dp_status_t                  status,
  output logic signed [dwpd_pkg::DRIVE_W-1:0]   out_left_drive,
  output logic signed [dwpd_pkg::DRIVE_W-1:0]   out_right_drive,
  output logic                                  out_move_done
);

  localparam int W = COUNT_WIDTH;

  // configuration registers
  logic [dwpd_pkg::GAIN_W-1:0]          kp_r, kd_r, sdiv_r;
  logic signed [dwpd_pkg::SENSOR_W-1:0] ltgt_r, rtgt_r;
  logic                                 use_sens_r, move_kind_r;
  logic [dwpd_pkg::DIST_W-1:0]          dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      kd_r        <= '0;
      sdiv_r      <= dwpd_pkg::GAIN_W'(1);
      ltgt_r      <= '0;
      rtgt_r      <= '0;
      use_sens_r  <= 1'b0;
      move_kind_r <= 1'b0;
      dist_r      <= '0;
    end else if (cfg_we) begin
      unique case (dwpd_pkg::cfg_reg_t'(cfg_index))
        dwpd_pkg::REG_KP:           kp_r        <= cfg_wdata[dwpd_pkg::GAIN_W-1:0];
        dwpd_pkg::REG_KD:           kd_r        <= cfg_wdata[dwpd_pkg::GAIN_W-1:0];
        dwpd_pkg::REG_SENSOR_DIV:   sdiv_r      <= cfg_wdata[dwpd_pkg::GAIN_W-1:0];
        dwpd_pkg::REG_LEFT_TARGET:  ltgt_r      <= cfg_wdata[dwpd_pkg::SENSOR_W-1:0];
        dwpd_pkg::REG_RIGHT_TARGET: rtgt_r      <= cfg_wdata[dwpd_pkg::SENSOR_W-1:0];
        dwpd_pkg::REG_USE_SENSORS:  use_sens_r  <= cfg_wdata[0];
        dwpd_pkg::REG_MOVE_KIND:    move_kind_r <= cfg_wdata[0];
        dwpd_pkg::REG_DIST_TARGET:  dist_r      <= cfg_wdata[dwpd_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // sensor magnitude division, started with the word load
  logic [dwpd_pkg::QUO_W-1:0]  sens_mag;
  logic [dwpd_pkg::GAIN_W-1:0] div_eff;
  logic [dwpd_pkg::QUO_W-1:0]  quo;
  logic                        div_done;

  assign sens_mag = in_sensor_error[dwpd_pkg::SENSOR_W-1]
                  ? dwpd_pkg::QUO_W'(-in_sensor_error) : dwpd_pkg::QUO_W'(in_sensor_error);
  assign div_eff  = (sdiv_r == '0) ? dwpd_pkg::GAIN_W'(1) : sdiv_r;

  dwpd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == dwpd_pkg::OP_LOAD),
    .dividend (sens_mag),
    .divisor  (div_eff),
    .quotient (quo),
    .done     (div_done)
  );

  assign status.div_done = div_done;

  // captured input word
  logic [W-1:0] lc_r, rc_r;
  logic         sens_neg_r;

  always_ff @(posedge clk) begin
    if (cmd.op == dwpd_pkg::OP_LOAD) begin
      lc_r       <= in_left_count[W-1:0];
      rc_r       <= in_right_count[W-1:0];
      sens_neg_r <= in_sensor_error[dwpd_pkg::SENSOR_W-1];
    end
  end

  // control state
  logic [W-1:0]                        last_lc_r, last_rc_r;
  logic signed [dwpd_pkg::DRIVE_W-1:0] acc_l_r, acc_r_r;
  logic signed [dwpd_pkg::DRIVE_W-1:0] prev_l_r, prev_r_r;

  // error forming
  logic signed [W-1:0]                   ld, rd;
  logic signed [dwpd_pkg::FB_W-1:0]      fb;
  logic signed [dwpd_pkg::ERR_EXT_W-1:0] el_w, er_w;
  logic signed [dwpd_pkg::ERR_EXT_W-1:0] fb_x, ld_x, rd_x, lt_x, rt_x;

  assign ld   = lc_r - last_lc_r;
  assign rd   = rc_r - last_rc_r;
  assign fb   = !use_sens_r ? '0
              : sens_neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign fb_x = dwpd_pkg::ERR_EXT_W'(fb);
  assign ld_x = dwpd_pkg::ERR_EXT_W'(ld);
  assign rd_x = dwpd_pkg::ERR_EXT_W'(rd);
  assign lt_x = dwpd_pkg::ERR_EXT_W'(ltgt_r);
  assign rt_x = dwpd_pkg::ERR_EXT_W'(rtgt_r);
  assign el_w = lt_x - ld_x + fb_x;
  assign er_w = rt_x - rd_x - fb_x;

  // end-of-move metric, truncating halves toward zero
  logic signed [W:0]                 ls_x, rs_x, pick, pick_adj, half, metric;
  logic signed [dwpd_pkg::CMP_W-1:0] metric_x, dist_x;
  logic                              done_w;

  assign ls_x     = $signed({lc_r[W-1], lc_r});
  assign rs_x     = $signed({rc_r[W-1], rc_r});
  assign pick     = (move_kind_r == dwpd_pkg::MOVE_ROTATE) ? rs_x - ls_x : rs_x + ls_x;
  assign pick_adj = pick + $signed({{W{1'b0}}, pick[W]});
  assign half     = pick_adj >>> 1;
  assign metric   = ((move_kind_r == dwpd_pkg::MOVE_ROTATE) && half[W]) ? -half : half;
  assign metric_x = dwpd_pkg::CMP_W'(metric);
  assign dist_x   = $signed({{(dwpd_pkg::CMP_W - dwpd_pkg::DIST_W){1'b0}}, dist_r});
  assign done_w   = metric_x >= dist_x;

  // shared multiplier operand select
  logic signed [dwpd_pkg::DRIVE_W-1:0] el_r, er_r;
  logic signed [dwpd_pkg::GAIN_W:0]    mul_a;
  logic signed [dwpd_pkg::DIFF_W-1:0]  mul_b;
  logic signed [dwpd_pkg::PROD_W-1:0]  mul_p;
  logic signed [dwpd_pkg::PROD_W-1:0]  prod_r;
  logic signed [dwpd_pkg::STEP_W-1:0]  step_l_r, step_r_r;

  always_comb begin
    mul_a = $signed({1'b0, kp_r});
    mul_b = dwpd_pkg::DIFF_W'(el_r);
    case (cmd.mul_idx)
      dwpd_pkg::MUL_KP_LEFT: begin
        mul_a = $signed({1'b0, kp_r});
        mul_b = dwpd_pkg::DIFF_W'(el_r);
      end
      dwpd_pkg::MUL_KD_LEFT: begin
        mul_a = $signed({1'b0, kd_r});
        mul_b = dwpd_pkg::DIFF_W'(el_r) - dwpd_pkg::DIFF_W'(prev_l_r);
      end
      dwpd_pkg::MUL_KP_RIGHT: begin
        mul_a = $signed({1'b0, kp_r});
        mul_b = dwpd_pkg::DIFF_W'(er_r);
      end
      dwpd_pkg::MUL_KD_RIGHT: begin
        mul_a = $signed({1'b0, kd_r});
        mul_b = dwpd_pkg::DIFF_W'(er_r) - dwpd_pkg::DIFF_W'(prev_r_r);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // accumulator sums
  logic signed [dwpd_pkg::ACC_W-1:0] sum_l, sum_r;

  assign sum_l = dwpd_pkg::ACC_W'(acc_l_r) + dwpd_pkg::ACC_W'(step_l_r);
  assign sum_r = dwpd_pkg::ACC_W'(acc_r_r) + dwpd_pkg::ACC_W'(step_r_r);

  // control state registers, cleared by reset and by a restart word
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == dwpd_pkg::OP_CLEAR) begin
      last_lc_r <= '0;
      last_rc_r <= '0;
      acc_l_r   <= '0;
      acc_r_r   <= '0;
      prev_l_r  <= '0;
      prev_r_r  <= '0;
    end else begin
      if (cmd.op == dwpd_pkg::OP_ERR) begin
        last_lc_r <= lc_r;
        last_rc_r <= rc_r;
      end
      if (cmd.op == dwpd_pkg::OP_ACC) begin
        acc_l_r  <= dwpd_pkg::sat32(sum_l);
        acc_r_r  <= dwpd_pkg::sat32(sum_r);
        prev_l_r <= el_r;
        prev_r_r <= er_r;
      end
    end
  end

  // working registers
  logic done_r;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      dwpd_pkg::OP_CLEAR: begin
        done_r <= 1'b0;
      end
      dwpd_pkg::OP_ERR: begin
        el_r   <= dwpd_pkg::sat32(dwpd_pkg::ACC_W'(el_w));
        er_r   <= dwpd_pkg::sat32(dwpd_pkg::ACC_W'(er_w));
        done_r <= done_w;
      end
      dwpd_pkg::OP_MUL: begin
        prod_r <= mul_p;
        case (cmd.mul_idx)
          dwpd_pkg::MUL_KD_LEFT:  step_l_r <= prod_r;
          dwpd_pkg::MUL_KP_RIGHT: step_l_r <= step_l_r + prod_r;
          dwpd_pkg::MUL_KD_RIGHT: step_r_r <= prod_r;
          dwpd_pkg::MUL_DRAIN:    step_r_r <= step_r_r + prod_r;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.op == dwpd_pkg::OP_OUT) begin
      out_left_drive  <= acc_l_r;
      out_right_drive <= acc_r_r;
      out_move_done   <= done_r;
    end
  end

endmodule

>>> sv/dwpd_ctrl.sv
// controller: sequences load or clear, divide, error, multiply, accumulate and output steps
`timescale 1ns / 1ps

module dwpd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_req_type,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dwpd_pkg::dp_status_t  status,
  output dwpd_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ERR,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [dwpd_pkg::MUL_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = dwpd_pkg::OP_NONE;
    cmd.mul_idx   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == dwpd_pkg::REQ_RESTART) begin
            cmd.op    = dwpd_pkg::OP_CLEAR;
            state_nxt = S_OUT;
          end else begin
            cmd.op    = dwpd_pkg::OP_LOAD;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.op    = dwpd_pkg::OP_ERR;
        cnt_nxt   = dwpd_pkg::MUL_KP_LEFT;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op = dwpd_pkg::OP_MUL;
        if (cnt_r == dwpd_pkg::MUL_DRAIN) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ACC: begin
        cmd.op    = dwpd_pkg::OP_ACC;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = dwpd_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a restart word goes straight to the output step
  a_restart_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == dwpd_pkg::REQ_RESTART |=> state_r == S_OUT)
    else $error("restart word did not go to output step");

  // divider completion is only seen while waiting for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> state_r == S_DIV)
    else $error("divider done outside divide step");

  // multiply step counter stays within the sequence
  a_mul_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> cnt_r <= dwpd_pkg::MUL_DRAIN)
    else $error("multiply step counter out of range");

  // a tick word leaves the block busy for the divide
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == dwpd_pkg::REQ_TICK |=> !in_ready && state_r == S_DIV)
    else $error("tick word did not start the divide");

  // the output word is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == dwpd_pkg::OP_OUT |-> !out_valid_r || out_ready)
    else $error("output word overwritten while waiting");

endmodule

>>> sv/dual_wheel_pd_speed_control_core.sv
// Dual-wheel incremental PD speed controller, top level.
//
// in_chan carries one word per control tick: req_type, the absolute left and
// right encoder counts and the wall-sensor error. req_type restart clears the
// count, error and drive state and answers with zero drives and move_done 0.
// out_chan returns one word per input word: both saturated drive values and
// move_done. Gains, targets and the distance threshold are written on the cfg
// port (cfg_we, cfg_index, cfg_wdata); the user must write them only while no
// word is in flight, which the block itself does not enforce.
// A tick word passes through the sensor divider, four quotient bits per step,
// a wait for it to finish, the error step, the single shared multiplier (four
// products plus a drain), the accumulate step and the output load. A restart
// word goes straight to the output load. One word is in work at a time: no
// new word is accepted before the output load of the last one.
// The result sits in an output register, so the next word is accepted while it
// waits; a stalled receiver holds back only the following result.
// Reset (rst_n low, synchronous) clears sequencing, count, error and drive
// state and restores register defaults; data and output registers are not reset.
`timescale 1ns / 1ps

module dual_wheel_pd_speed_control_core #(
  parameter int COUNT_WIDTH = dwpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dwpd_in_if.sink                          in_chan,
  dwpd_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [dwpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  dwpd_pkg::dp_cmd_t    cmd;
  dwpd_pkg::dp_status_t status;

  // sequencing
  dwpd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // arithmetic and state
  dwpd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_left_count   (in_chan.left_count),
    .in_right_count  (in_chan.right_count),
    .in_sensor_error (in_chan.sensor_error),
    .cmd             (cmd),
    .status          (status),
    .out_left_drive  (out_chan.left_drive),
    .out_right_drive (out_chan.right_drive),
    .out_move_done   (out_chan.move_done)
  );

endmodule
